// File: design/h2r_pkg.sv
// h2r_pkg: shared widths, constants and types of the HSL to RGB converter.
// No dependencies; every other design file imports it.

package h2r_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE_I     = 1 << FRAC_BITS;

    localparam int VW   = FRAC_BITS + 1;   // fraction in [0, 1.0]
    localparam int UW   = FRAC_BITS + 2;   // wrapped hue argument 3*t*ONE, 0..3*ONE
    localparam int SW   = FRAC_BITS + 4;   // signed hue argument before the wrap
    localparam int BW   = 8;               // color channel width
    localparam int NSTG = 5;               // pipeline register stages
    localparam int NCH  = 3;               // red, green, blue

    localparam logic [VW-1:0] ONE  = VW'(ONE_I);
    localparam logic [VW-1:0] HALF = VW'(ONE_I / 2);

    typedef logic [VW-1:0] t_frac;
    typedef logic [UW-1:0] t_harg;
    typedef logic [BW-1:0] t_byte;

    // Piece of the hue ramp that a channel falls in
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HOLD,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    // Per-stage load enables from the pipeline controller
    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_ctl;

endpackage

// File: design/h2r_if.sv
// h2r_if: valid/ready channel interfaces for HSL input and RGB output transactions.
// Depends on h2r_pkg for the payload widths.

interface h2r_hsl_if import h2r_pkg::*; ();
    logic  valid;
    logic  ready;
    t_frac hue;
    t_frac saturation;
    t_frac lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface h2r_rgb_if import h2r_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte red;
    t_byte green;
    t_byte blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: design/h2r_ctrl.sv
// h2r_ctrl: valid bits and per-stage load enables of the converter pipeline.
// Depends on h2r_pkg.

module h2r_ctrl import h2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    // A stage loads when it is empty or its content moves on; bubbles collapse
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_ctl.en    = w_en;

endmodule

// File: design/h2r_qp.sv
// h2r_qp: first two pipeline stages: input clamp, L*S product, q and p, and the
// wrapped hue argument of each channel. Depends on h2r_pkg.

module h2r_qp import h2r_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_frac     i_hue,
    input  t_frac     i_sat,
    input  t_frac     i_lgt,
    output t_frac     o_p,
    output t_frac     o_q,
    output t_frac     o_d,
    output t_frac     o_l,
    output logic      o_zero,
    output t_harg     o_u [NCH]
);

    localparam logic signed [SW-1:0] C_ONE   = SW'(ONE_I);
    localparam logic signed [SW-1:0] C_THREE = SW'(3 * ONE_I);
    localparam logic signed [SW-1:0] C_OFS [NCH] = '{C_ONE, SW'(0), -C_ONE};

    // Stage 1
    t_frac             w_h, w_s, w_l;
    logic [2*VW-1:0]   w_ls;
    t_harg             w_h3;
    t_frac             r_s1_l, r_s1_s;
    logic [2*VW-1:0]   r_s1_ls;
    t_harg             r_s1_h3;
    logic              r_s1_zero;

    // Stage 2
    t_frac             w_hi;
    logic              w_lo;
    logic [VW:0]       w_q_wide;
    t_frac             w_q, w_p;
    logic signed [SW-1:0] w_us [NCH];
    t_harg             w_u [NCH];
    t_frac             r_p, r_q, r_d, r_l;
    logic              r_zero;
    t_harg             r_u [NCH];

    always_comb begin
        w_h  = (i_hue > ONE) ? ONE : i_hue;
        w_s  = (i_sat > ONE) ? ONE : i_sat;
        w_l  = (i_lgt > ONE) ? ONE : i_lgt;
        w_ls = (2*VW)'(w_l) * (2*VW)'(w_s);
        w_h3 = UW'(w_h) + {w_h, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_l    <= w_l;
            r_s1_s    <= w_s;
            r_s1_ls   <= w_ls;
            r_s1_h3   <= w_h3;
            r_s1_zero <= (w_s == '0);
        end
    end

    // q = L + floor(LS) below one half, else L + S - ceil(LS)
    always_comb begin
        w_hi = VW'(r_s1_ls >> FRAC_BITS);
        w_lo = |r_s1_ls[FRAC_BITS-1:0];
        if (r_s1_l < HALF) begin
            w_q_wide = {1'b0, r_s1_l} + {1'b0, w_hi};
        end else begin
            w_q_wide = {1'b0, r_s1_l} + {1'b0, r_s1_s} - {1'b0, w_hi} - (VW+1)'(w_lo);
        end
        w_q = w_q_wide[VW-1:0];
        w_p = VW'({r_s1_l, 1'b0} - {1'b0, w_q});
    end

    // Shift the hue by a third per channel and wrap once into [0, 3*ONE]
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_us[c] = $signed(SW'(r_s1_h3)) + C_OFS[c];
            if (w_us[c] < 0) begin
                w_us[c] = w_us[c] + C_THREE;
            end else if (w_us[c] > C_THREE) begin
                w_us[c] = w_us[c] - C_THREE;
            end
            w_u[c] = UW'(w_us[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_p    <= w_p;
            r_q    <= w_q;
            r_d    <= w_q - w_p;
            r_l    <= r_s1_l;
            r_zero <= r_s1_zero;
            r_u    <= w_u;
        end
    end

    assign o_p    = r_p;
    assign o_q    = r_q;
    assign o_d    = r_d;
    assign o_l    = r_l;
    assign o_zero = r_zero;
    assign o_u    = r_u;

endmodule

// File: design/h2r_chan.sv
// h2r_chan: last three pipeline stages of one color channel: ramp segment,
// ramp multiply, and scaling to an 8-bit intensity. Depends on h2r_pkg.

module h2r_chan import h2r_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_frac     i_p,
    input  t_frac     i_q,
    input  t_frac     i_d,
    input  t_frac     i_l,
    input  logic      i_zero,
    input  t_harg     i_u,
    output t_byte     o_byte
);

    localparam logic [UW:0]   C_ONE_X   = (UW+1)'(ONE_I);
    localparam logic [UW:0]   C_THREE_X = (UW+1)'(3 * ONE_I);
    localparam logic [UW:0]   C_FOUR_X  = (UW+1)'(4 * ONE_I);
    localparam logic [UW-1:0] C_TWO     = UW'(2 * ONE_I);
    localparam logic [VW+BW-1:0] C_BMAX = (VW+BW)'((1 << BW) - 1);

    // Stage 3
    logic [UW:0]     w_u2;
    t_seg            w_seg;
    t_frac           w_m;
    t_seg            r_seg;
    t_frac           r_m, r_p, r_q, r_d, r_l;
    logic            r_zero;

    // Stage 4
    logic [2*VW-1:0] w_prod;
    t_frac           w_v;
    t_frac           r_v;

    // Stage 5
    logic [VW+BW-1:0] w_scaled;
    logic [VW+BW-1:0] w_c;
    t_byte            w_byte;
    t_byte            r_byte;

    always_comb begin
        w_u2 = {i_u, 1'b0};
        w_m  = '0;
        priority if (w_u2 < C_ONE_X) begin
            w_seg = SEG_RISE;
            w_m   = VW'(w_u2);
        end else if (w_u2 < C_THREE_X) begin
            w_seg = SEG_HOLD;
        end else if (i_u < C_TWO) begin
            w_seg = SEG_FALL;
            w_m   = VW'(C_FOUR_X - w_u2);
        end else begin
            w_seg = SEG_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_seg  <= w_seg;
            r_m    <= w_m;
            r_p    <= i_p;
            r_q    <= i_q;
            r_d    <= i_d;
            r_l    <= i_l;
            r_zero <= i_zero;
        end
    end

    always_comb begin
        w_prod = (2*VW)'(r_d) * (2*VW)'(r_m);
        if (r_zero) begin
            w_v = r_l;
        end else begin
            unique case (r_seg)
                SEG_RISE, SEG_FALL: w_v = r_p + VW'(w_prod >> FRAC_BITS);
                SEG_HOLD:           w_v = r_q;
                SEG_LOW:            w_v = r_p;
                default:            w_v = r_p;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_v <= w_v;
        end
    end

    // 255*v as a shift and subtract, truncate, saturate
    always_comb begin
        w_scaled = {r_v, {BW{1'b0}}} - (VW+BW)'(r_v);
        w_c      = w_scaled >> FRAC_BITS;
        w_byte   = (w_c > C_BMAX) ? {BW{1'b1}} : w_c[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_byte <= w_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: design/hsl_to_rgb_converter.sv
// HSL to RGB converter: takes one HSL pixel per clock (hue, saturation and
// lightness as unsigned fractions with 16 fraction bits, values above 1.0 read
// as 1.0) and returns 8-bit red, green and blue. Five register stages: clamp and
// L*S product, q/p and hue wrap, ramp segment, ramp multiply, scaling by 255.
// With the output taken every cycle the rate is one pixel per clock. A stall
// at the output fills empty stages first and reaches the input ready only when
// all five stages hold a transaction. No state is kept between pixels.
// Depends on h2r_pkg, h2r_if, h2r_ctrl, h2r_qp and h2r_chan.

module hsl_to_rgb_converter import h2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    h2r_hsl_if.sink    i_hsl,
    h2r_rgb_if.source  o_rgb
);

    t_pipe_ctl w_ctl;
    t_frac     w_p, w_q, w_d, w_l;
    logic      w_zero;
    t_harg     w_u [NCH];
    t_byte     w_byte [NCH];

    h2r_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_hsl.valid),
        .i_out_ready (o_rgb.ready),
        .o_in_ready  (i_hsl.ready),
        .o_out_valid (o_rgb.valid),
        .o_ctl       (w_ctl)
    );

    h2r_qp u_qp (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_hue  (i_hsl.hue),
        .i_sat  (i_hsl.saturation),
        .i_lgt  (i_hsl.lightness),
        .o_p    (w_p),
        .o_q    (w_q),
        .o_d    (w_d),
        .o_l    (w_l),
        .o_zero (w_zero),
        .o_u    (w_u)
    );

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        h2r_chan u_chan (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_p    (w_p),
            .i_q    (w_q),
            .i_d    (w_d),
            .i_l    (w_l),
            .i_zero (w_zero),
            .i_u    (w_u[c]),
            .o_byte (w_byte[c])
        );
    end

    assign o_rgb.red   = w_byte[0];
    assign o_rgb.green = w_byte[1];
    assign o_rgb.blue  = w_byte[2];

endmodule

// File: design/h2r_checker.sv
// h2r_checker: port-level assertions for hsl_to_rgb_converter and the bind
// that attaches them. Depends on h2r_pkg and the converter's ports.

module h2r_checker import h2r_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input t_frac i_sat,
    input t_frac i_lgt,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_byte i_red,
    input t_byte i_green,
    input t_byte i_blue
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_red, i_green, i_blue}))
        else $error("stalled output payload changed");

    // Input backpressure only while the output holds a stalled result
    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    // Black in, black out when the output never stalls
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_sat == '0 && i_lgt == '0
        ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid && i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("zero lightness grey did not give black");

    // Full lightness grey gives white
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_sat == '0 && i_lgt == ONE
        ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid && i_red == '1 && i_green == '1 && i_blue == '1)
        else $error("full lightness grey did not give white");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsl.valid),
    .i_in_ready  (i_hsl.ready),
    .i_sat       (i_hsl.saturation),
    .i_lgt       (i_hsl.lightness),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
